@@ hw/rtl/nmea_sentence_checksum_framer_core_defines.svh @@
// Assertion macros for the checker file of the NMEA checksum framer.
// No dependencies; the including file supplies clock, reset and signals.
`ifndef NMEA_SENTENCE_CHECKSUM_FRAMER_CORE_DEFINES_SVH
`define NMEA_SENTENCE_CHECKSUM_FRAMER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define NSCF_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("nscf assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define NSCF_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("nscf assertion failed");

`endif

@@ hw/rtl/nscf_pkg.sv @@
// Package for the NMEA checksum framer: character codes, body limit,
// status codes and the result beat type. No dependencies.
package nscf_pkg;

  localparam logic [7:0] CharDollar = 8'h24;
  localparam logic [7:0] CharStar   = 8'h2A;

  // Longest body that is counted; longer bodies are flagged too long.
  localparam logic [7:0] MaxBody = 8'd128;

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StMismatch = 2'd1,
    StBadHex   = 2'd2,
    StTooLong  = 2'd3
  } status_e;

  typedef struct packed {
    status_e    status;
    logic [7:0] computed_sum;
    logic [7:0] received_sum;
    logic [7:0] body_length;
  } result_t;

endpackage

@@ hw/rtl/nscf_hex_dec.sv @@
// ASCII hex digit decoder for the NMEA checksum framer.
// No package dependencies.
module nscf_hex_dec (
  input  logic [7:0] char_i,
  output logic [3:0] nibble_o,
  output logic       bad_o
);

  logic [7:0] diff;

  always_comb begin
    diff     = 8'd0;
    nibble_o = 4'd0;
    bad_o    = 1'b0;
    if (char_i inside {[8'h30:8'h39]}) begin
      diff     = char_i - 8'h30;
      nibble_o = diff[3:0];
    end else if (char_i inside {[8'h41:8'h46]}) begin
      diff     = char_i - 8'h37;
      nibble_o = diff[3:0];
    end else if (char_i inside {[8'h61:8'h66]}) begin
      diff     = char_i - 8'h57;
      nibble_o = diff[3:0];
    end else begin
      bad_o = 1'b1;
    end
  end

endmodule

@@ hw/rtl/nmea_sentence_checksum_framer_core.sv @@
// Top level of the NMEA 0183 sentence checksum framer.
// Depends on nscf_pkg and nscf_hex_dec.
//
// Usage:
//   The input channel carries one character per beat (data_byte_i). Bytes
//   are skipped until a '$'; every byte after it up to the next '*' is
//   XORed into the checksum and counted (saturating at 128). The two bytes
//   after the '*' are read as hex digits. On the second one the block
//   emits one result beat: status, computed and received sums and length.
//   The result is registered in the output register, or in the skid register
//   while the receiver stalls. Throughput: one byte per cycle while in_stall_o
//   is low, set by the single phase register and the result register.
//   When the receiver stalls, a held result sits in the output register
//   and bytes keep flowing; a second finished result goes to a skid
//   register, and only while that skid register is full is in_stall_o
//   high.
//   Reset clears the phase to hunting for '$' and empties both result
//   registers; the result payload holds no defined value until written.
module nmea_sentence_checksum_framer_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] status_o,
  output logic [7:0] computed_sum_o,
  output logic [7:0] received_sum_o,
  output logic [7:0] body_length_o
);
  import nscf_pkg::*;

  localparam logic [1:0] PhHunt = 2'd0;
  localparam logic [1:0] PhBody = 2'd1;
  localparam logic [1:0] PhHex1 = 2'd2;
  localparam logic [1:0] PhHex2 = 2'd3;

  logic [1:0] phase_q, phase_d;
  logic [7:0] running_xor_q, running_xor_d;
  logic [3:0] high_nibble_q, high_nibble_d;
  logic       hex_error_q, hex_error_d;
  logic [7:0] length_count_q, length_count_d;
  logic       overflow_seen_q, overflow_seen_d;

  logic       out_valid_q, out_valid_d;
  logic       skid_valid_q, skid_valid_d;
  result_t    out_q, out_d;
  result_t    skid_q, skid_d;

  logic       in_acc;
  logic       out_free;
  logic [3:0] nibble;
  logic       bad;
  logic       res_valid;
  result_t    res;
  logic [7:0] recv;
  logic       err;

  nscf_hex_dec u_hex_dec (
    .char_i   (data_byte_i),
    .nibble_o (nibble),
    .bad_o    (bad)
  );

  assign in_stall_o = skid_valid_q;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  assign recv = {high_nibble_q, nibble};
  assign err  = hex_error_q | bad;

  always_comb begin
    res.computed_sum = running_xor_q;
    res.received_sum = recv;
    res.body_length  = length_count_q;
    if (overflow_seen_q) begin
      res.status = StTooLong;
    end else if (err) begin
      res.status = StBadHex;
    end else if (recv != running_xor_q) begin
      res.status = StMismatch;
    end else begin
      res.status = StOk;
    end
  end

  always_comb begin
    phase_d         = phase_q;
    running_xor_d   = running_xor_q;
    high_nibble_d   = high_nibble_q;
    hex_error_d     = hex_error_q;
    length_count_d  = length_count_q;
    overflow_seen_d = overflow_seen_q;
    res_valid       = 1'b0;
    if (in_acc) begin
      case (phase_q)
        PhHunt: begin
          if (data_byte_i == CharDollar) begin
            phase_d         = PhBody;
            running_xor_d   = 8'd0;
            high_nibble_d   = 4'd0;
            hex_error_d     = 1'b0;
            length_count_d  = 8'd0;
            overflow_seen_d = 1'b0;
          end
        end
        PhBody: begin
          if (data_byte_i == CharStar) begin
            phase_d = PhHex1;
          end else begin
            running_xor_d = running_xor_q ^ data_byte_i;
            if (length_count_q < MaxBody) begin
              length_count_d = length_count_q + 8'd1;
            end else begin
              overflow_seen_d = 1'b1;
            end
          end
        end
        PhHex1: begin
          high_nibble_d = nibble;
          hex_error_d   = hex_error_q | bad;
          phase_d       = PhHex2;
        end
        PhHex2: begin
          hex_error_d = err;
          res_valid   = 1'b1;
          phase_d     = PhHunt;
        end
        default: begin
          phase_d = PhHunt;
        end
      endcase
    end
  end

  // Output register plus one skid entry. While the skid entry is full the
  // input is stalled, so a new result never meets a full skid.
  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (out_free) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        out_valid_d  = 1'b1;
        skid_valid_d = 1'b0;
      end else if (res_valid) begin
        out_d       = res;
        out_valid_d = 1'b1;
      end else begin
        out_valid_d = 1'b0;
      end
    end else if (res_valid) begin
      skid_d       = res;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q         <= PhHunt;
      running_xor_q   <= 8'd0;
      high_nibble_q   <= 4'd0;
      hex_error_q     <= 1'b0;
      length_count_q  <= 8'd0;
      overflow_seen_q <= 1'b0;
      out_valid_q     <= 1'b0;
      skid_valid_q    <= 1'b0;
    end else begin
      phase_q         <= phase_d;
      running_xor_q   <= running_xor_d;
      high_nibble_q   <= high_nibble_d;
      hex_error_q     <= hex_error_d;
      length_count_q  <= length_count_d;
      overflow_seen_q <= overflow_seen_d;
      out_valid_q     <= out_valid_d;
      skid_valid_q    <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_q.status;
  assign computed_sum_o = out_q.computed_sum;
  assign received_sum_o = out_q.received_sum;
  assign body_length_o  = out_q.body_length;

endmodule

@@ hw/rtl/nscf_checker.sv @@
// Port-level checker for the NMEA checksum framer, bound to the top level.
// Depends on nscf_pkg and the assertion macros header.
`include "nmea_sentence_checksum_framer_core_defines.svh"

module nscf_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [1:0] status_o,
  input logic [7:0] computed_sum_o,
  input logic [7:0] received_sum_o,
  input logic [7:0] body_length_o
);
  import nscf_pkg::*;

  logic        out_held;
  logic [1:0]  st_ok;
  logic [1:0]  st_mis;
  logic [1:0]  st_long;
  logic [25:0] out_payload;
  logic        sums_equal;
  logic        ok_beat;
  logic        mis_beat;
  logic        long_beat;

  assign out_held    = out_valid_o && out_stall_i;
  assign st_ok       = StOk;
  assign st_mis      = StMismatch;
  assign st_long     = StTooLong;
  assign out_payload = {status_o, computed_sum_o, received_sum_o, body_length_o};
  assign sums_equal  = (computed_sum_o == received_sum_o);
  assign ok_beat     = out_valid_o && (status_o == st_ok);
  assign mis_beat    = out_valid_o && (status_o == st_mis);
  assign long_beat   = out_valid_o && (status_o == st_long);

  `NSCF_ASSERT_NEXT(a_out_valid_holds, clk_i, rst_ni, out_held, out_valid_o)
  `NSCF_ASSERT_NEXT(a_out_payload_holds, clk_i, rst_ni, out_held, $stable(out_payload))
  `NSCF_ASSERT_NOW(a_ok_sums_match, clk_i, rst_ni, ok_beat, sums_equal)
  `NSCF_ASSERT_NOW(a_mismatch_sums_differ, clk_i, rst_ni, mis_beat, !sums_equal)
  `NSCF_ASSERT_NOW(a_too_long_saturated, clk_i, rst_ni, long_beat, body_length_o == MaxBody)

endmodule

bind nmea_sentence_checksum_framer_core nscf_checker u_nscf_checker (.*);

@@ tb/nmea_sentence_checksum_framer_core_tb.sv @@
// Self-checking testbench for the NMEA sentence checksum framer core.
// Feeds directed and random character streams and checks every result beat.
// Depends on nscf_pkg and nmea_sentence_checksum_framer_core.
module nmea_sentence_checksum_framer_core_tb;
  import nscf_pkg::*;

  localparam int ClkHalf    = 6;
  localparam int QuietLimit = 2000;
  localparam int RandChars  = 600;

  typedef enum logic [1:0] {
    HuntDollar,
    InBody,
    HexHigh,
    HexLow
  } framer_phase_e;

  typedef struct {
    logic [7:0] ch;
    bit         drain_first;
  } stream_char_t;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic [7:0] data_byte_i = 8'h00;
  logic       out_stall_i = 1'b0;
  logic       in_stall_o;
  logic       out_valid_o;
  logic [1:0] status_o;
  logic [7:0] computed_sum_o;
  logic [7:0] received_sum_o;
  logic [7:0] body_length_o;

  stream_char_t pending_chars[$];
  result_t      expected_results[$];
  int           mismatches  = 0;
  int           quiet_count = 0;
  int           cycle_count = 0;

  // Sentence tracker state, updated for every accepted character beat.
  framer_phase_e trk_phase;
  logic [7:0]    trk_xor;
  logic [7:0]    trk_length;
  logic [3:0]    trk_high;
  bit            trk_hex_bad;
  bit            trk_overflow;

  nmea_sentence_checksum_framer_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .data_byte_i   (data_byte_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .computed_sum_o(computed_sum_o),
    .received_sum_o(received_sum_o),
    .body_length_o (body_length_o)
  );

  always #ClkHalf clk_i = ~clk_i;

  // Random gaps on both sides, except for a calm window in the middle of the run.
  function automatic bit take_break();
    if (cycle_count >= 500 && cycle_count < 900) return 1'b0;
    return $urandom_range(0, 99) < 36;
  endfunction

  // Bit 4 flags a character that is not a hex digit; its value then reads as zero.
  function automatic logic [4:0] decode_hex_digit(input logic [7:0] c);
    if (c >= "0" && c <= "9") return {1'b0, 4'(c - "0")};
    if (c >= "A" && c <= "F") return {1'b0, 4'(c - "A" + 8'd10)};
    if (c >= "a" && c <= "f") return {1'b0, 4'(c - "a" + 8'd10)};
    return 5'h10;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return 8'("0") + 8'(n);
    return ($urandom_range(0, 1) ? 8'("a") : 8'("A")) + 8'(n) - 8'd10;
  endfunction

  task automatic track_char(input logic [7:0] c);
    logic [4:0] digit;
    result_t    res;
    digit = decode_hex_digit(c);
    case (trk_phase)
      HuntDollar: begin
        if (c == CharDollar) begin
          trk_phase    = InBody;
          trk_xor      = 8'h00;
          trk_high     = 4'h0;
          trk_hex_bad  = 1'b0;
          trk_length   = 8'h00;
          trk_overflow = 1'b0;
        end
      end
      InBody: begin
        if (c == CharStar) begin
          trk_phase = HexHigh;
        end else begin
          trk_xor = trk_xor ^ c;
          if (trk_length < MaxBody) trk_length = trk_length + 8'd1;
          else trk_overflow = 1'b1;
        end
      end
      HexHigh: begin
        trk_high = digit[3:0];
        if (digit[4]) trk_hex_bad = 1'b1;
        trk_phase = HexLow;
      end
      default: begin
        if (digit[4]) trk_hex_bad = 1'b1;
        res.received_sum = {trk_high, digit[3:0]};
        res.computed_sum = trk_xor;
        res.body_length  = trk_length;
        if (trk_overflow) res.status = StTooLong;
        else if (trk_hex_bad) res.status = StBadHex;
        else if (res.received_sum != trk_xor) res.status = StMismatch;
        else res.status = StOk;
        expected_results.push_back(res);
        trk_phase = HuntDollar;
      end
    endcase
  endtask

  task automatic report_mismatch(input string what, input int want, input int got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $realtime, what, want, got);
    end
  endtask

  task automatic check_result();
    result_t want;
    if (expected_results.size() == 0) begin
      report_mismatch("unexpected result, status", -1, status_o);
    end else begin
      want = expected_results.pop_front();
      if (status_o != want.status) report_mismatch("status", want.status, status_o);
      if (computed_sum_o != want.computed_sum) begin
        report_mismatch("computed_sum", want.computed_sum, computed_sum_o);
      end
      if (received_sum_o != want.received_sum) begin
        report_mismatch("received_sum", want.received_sum, received_sum_o);
      end
      if (body_length_o != want.body_length) begin
        report_mismatch("body_length", want.body_length, body_length_o);
      end
    end
  endtask

  // Character driver: holds a stalled beat, otherwise takes the next queued character or idles for a gap or a drain.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i   <= 1'b0;
      data_byte_i  <= 8'h00;
      trk_phase    = HuntDollar;
      trk_xor      = 8'h00;
      trk_high     = 4'h0;
      trk_hex_bad  = 1'b0;
      trk_length   = 8'h00;
      trk_overflow = 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) track_char(data_byte_i);
      if (!in_valid_i || !in_stall_o) begin
        if (pending_chars.size() == 0 || take_break() ||
            (pending_chars[0].drain_first && expected_results.size() != 0)) begin
          in_valid_i <= 1'b0;
        end else begin
          in_valid_i  <= 1'b1;
          data_byte_i <= pending_chars[0].ch;
          void'(pending_chars.pop_front());
        end
      end
    end
  end

  // Result monitor with random back-pressure.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) check_result();
      out_stall_i <= take_break();
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      cycle_count <= cycle_count + 1;
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_count <= 0;
      end else if (quiet_count >= QuietLimit) begin
        $display("Regression FAIL");
        $finish;
      end else begin
        quiet_count <= quiet_count + 1;
      end
    end
  end

  task automatic add_char(input logic [7:0] c, input bit drain);
    stream_char_t item;
    item.ch          = c;
    item.drain_first = drain;
    pending_chars.push_back(item);
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) add_char(s[i], 1'b0);
  endtask

  // One sentence with leading noise, a random body and a mostly correct checksum.
  task automatic add_sentence(input int body_len, input bit drain);
    logic [7:0] sum;
    logic [7:0] ch;
    int         noise;
    int         mode;
    sum   = 8'h00;
    noise = $urandom_range(0, 3);
    for (int i = 0; i < noise; i++) begin
      add_char(8'($urandom_range(0, 255)), drain);
      drain = 1'b0;
    end
    add_char(CharDollar, drain);
    for (int i = 0; i < body_len; i++) begin
      if ($urandom_range(0, 3) == 0) ch = 8'($urandom_range(0, 255));
      else ch = 8'($urandom_range(8'h20, 8'h7E));
      // Mostly keep the body intact; a stray star now and then breaks the frame.
      if (ch == CharStar && $urandom_range(0, 3) != 0) ch = CharDollar;
      sum = sum ^ ch;
      add_char(ch, 1'b0);
    end
    add_char(CharStar, 1'b0);
    mode = $urandom_range(0, 9);
    if (mode == 7) sum = sum ^ 8'($urandom_range(1, 255));
    if (mode == 9) begin
      add_char(8'($urandom_range(0, 255)), 1'b0);
      add_char(8'($urandom_range(0, 255)), 1'b0);
    end else if (mode == 8) begin
      if ($urandom_range(0, 1)) begin
        add_char(8'($urandom_range(0, 255)), 1'b0);
        add_char(hex_char(sum[3:0]), 1'b0);
      end else begin
        add_char(hex_char(sum[7:4]), 1'b0);
        add_char(8'($urandom_range(0, 255)), 1'b0);
      end
    end else begin
      add_char(hex_char(sum[7:4]), 1'b0);
      add_char(hex_char(sum[3:0]), 1'b0);
    end
  endtask

  initial begin
    int body_len;
    int random_start;
    // Noise before the first dollar, an empty body, good sums with a lowercase hex digit,
    // a mismatch and bad hex digits including a dollar and a star.
    add_char(8'hFF, 1'b0);
    add_char(8'h00, 1'b0);
    add_text("$*00");
    add_text("$A*41");
    add_text("$j*6a");
    add_text("$1*00");
    add_text("$*$*");
    add_text("$Z*G5");
    // Bodies exactly at the limit and one past it, after a full drain.
    add_sentence(MaxBody, 1'b1);
    add_sentence(MaxBody + 1, 1'b0);
    random_start = pending_chars.size();
    while (pending_chars.size() - random_start < RandChars) begin
      if ($urandom_range(0, 39) == 0) body_len = $urandom_range(MaxBody - 2, 200);
      else if ($urandom_range(0, 9) == 0) body_len = $urandom_range(0, 60);
      else body_len = $urandom_range(0, 16);
      add_sentence(body_len, $urandom_range(0, 19) == 0);
    end

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    do begin
      @(posedge clk_i);
    end while (pending_chars.size() != 0 || in_valid_i || expected_results.size() != 0);
    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
